FILE: src/irc_lt_pkg.sv
// Shared types, codes and the per-byte parse function of the IRC line tokenizer.
package irc_lt_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PUSH_MAX    = 3;

    typedef enum logic [2:0] {
        KIND_PREFIX = 3'd0,
        KIND_CMD    = 3'd1,
        KIND_PARAM  = 3'd2,
        KIND_TRAIL  = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_LINE_START   = 4'd0,
        PH_PREFIX_FIRST = 4'd1,
        PH_PREFIX_REST  = 4'd2,
        PH_CMD_START    = 4'd3,
        PH_CMD_REST     = 4'd4,
        PH_PARAM_GAP    = 4'd5,
        PH_PARAM_REST   = 4'd6,
        PH_TRAIL_FIRST  = 4'd7,
        PH_TRAIL_REST   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      field_kind;
        logic [3:0] param_index;
        logic       token_start;
        logic       last_of_run;
    } rec_t;

    typedef struct packed {
        logic       emit;
        rec_t       rec;
        phase_t     phase;
        logic [3:0] count;
    } feed_t;

    typedef struct packed {
        logic at_line_start;
        logic cr_pending;
    } parse_status_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= CH_LC_A && c <= CH_LC_Z) ? (c & ~CASE_BIT) : c;
    endfunction

    function automatic logic [3:0] bump(input logic [3:0] cnt, input logic [3:0] top);
        bump = (cnt < top) ? cnt + 4'd1 : cnt;
    endfunction

    function automatic rec_t mk_rec(input logic [7:0] b, input kind_t k,
                                    input logic [3:0] idx, input logic st);
        rec_t r;
        r.out_byte    = b;
        r.field_kind  = k;
        r.param_index = idx;
        r.token_start = st;
        r.last_of_run = 1'b0;
        mk_rec = r;
    endfunction

    // One byte through the parse position: what it emits and where it leaves the state.
    function automatic feed_t feed(input phase_t ph, input logic [3:0] cnt,
                                   input logic [7:0] c, input logic [3:0] top);
        feed_t f;
        f.emit  = 1'b0;
        f.rec   = mk_rec(c, KIND_TRAIL, 4'd0, 1'b0);
        f.phase = ph;
        f.count = cnt;
        case (ph)
            PH_LINE_START:
            begin
                if (c == CH_COLON)
                begin
                    f.phase = PH_PREFIX_FIRST;
                end
                else if (c == CH_SPACE)
                begin
                    f.phase = PH_PARAM_GAP;
                end
                else
                begin
                    f.emit  = 1'b1;
                    f.rec   = mk_rec(upcase(c), KIND_CMD, 4'd0, 1'b1);
                    f.phase = PH_CMD_REST;
                end
            end
            PH_PREFIX_FIRST, PH_PREFIX_REST:
            begin
                if (c == CH_SPACE)
                begin
                    f.phase = PH_CMD_START;
                end
                else
                begin
                    f.emit  = 1'b1;
                    f.rec   = mk_rec(c, KIND_PREFIX, 4'd0, ph == PH_PREFIX_FIRST);
                    f.phase = PH_PREFIX_REST;
                end
            end
            PH_CMD_START:
            begin
                if (c != CH_SPACE)
                begin
                    f.emit  = 1'b1;
                    f.rec   = mk_rec(upcase(c), KIND_CMD, 4'd0, 1'b1);
                    f.phase = PH_CMD_REST;
                end
            end
            PH_CMD_REST:
            begin
                if (c == CH_SPACE)
                begin
                    f.phase = PH_PARAM_GAP;
                end
                else
                begin
                    f.emit = 1'b1;
                    f.rec  = mk_rec(upcase(c), KIND_CMD, 4'd0, 1'b0);
                end
            end
            PH_PARAM_GAP:
            begin
                if (c == CH_COLON)
                begin
                    f.phase = PH_TRAIL_FIRST;
                end
                else if (c != CH_SPACE)
                begin
                    f.emit  = 1'b1;
                    f.rec   = mk_rec(c, KIND_PARAM, cnt, 1'b1);
                    f.phase = PH_PARAM_REST;
                end
            end
            PH_PARAM_REST:
            begin
                if (c == CH_SPACE)
                begin
                    f.count = bump(cnt, top);
                    f.phase = PH_PARAM_GAP;
                end
                else
                begin
                    f.emit = 1'b1;
                    f.rec  = mk_rec(c, KIND_PARAM, cnt, 1'b0);
                end
            end
            PH_TRAIL_FIRST:
            begin
                f.emit  = 1'b1;
                f.rec   = mk_rec(c, KIND_TRAIL, 4'd0, 1'b1);
                f.phase = PH_TRAIL_REST;
            end
            default:
            begin
                f.emit  = 1'b1;
                f.rec   = mk_rec(c, KIND_TRAIL, 4'd0, 1'b0);
                f.phase = PH_TRAIL_REST;
            end
        endcase
        feed = f;
    endfunction

endpackage

FILE: src/irc_lt_parse.sv
// Parse state registers and the per-item logic that yields up to three tagged results.
module irc_lt_parse #(
    parameter int MAX_PARAMS = 15
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      accept,
    input  logic [7:0]                                data_byte,
    input  logic                                      end_of_line,
    output logic [irc_lt_pkg::PUSH_MAX-1:0]           push_valid,
    output irc_lt_pkg::rec_t [irc_lt_pkg::PUSH_MAX-1:0] push_rec,
    output irc_lt_pkg::parse_status_t                 status
);

    localparam logic [3:0] TOP = (MAX_PARAMS > 15) ? 4'd15 : 4'(MAX_PARAMS);

    irc_lt_pkg::phase_t phase_reg, phase_next;
    logic               cr_reg, cr_next;
    logic [3:0]         count_reg, count_next;

    irc_lt_pkg::feed_t  f_cr, f_byte;
    irc_lt_pkg::phase_t ph_mid;
    logic [3:0]         cnt_mid;
    logic               do_cr, do_byte;
    logic [3:0]         end_count;
    logic               is_lf, is_cr;

    always_comb
    begin
        is_lf   = (data_byte == irc_lt_pkg::CH_LF);
        is_cr   = (data_byte == irc_lt_pkg::CH_CR);
        // a held CR goes out unless the line ends on LF right after it
        do_cr   = cr_reg && !(end_of_line && is_lf);
        do_byte = end_of_line ? (!is_lf && !is_cr) : !is_cr;

        f_cr    = irc_lt_pkg::feed(phase_reg, count_reg, irc_lt_pkg::CH_CR, TOP);
        ph_mid  = do_cr ? f_cr.phase : phase_reg;
        cnt_mid = do_cr ? f_cr.count : count_reg;
        f_byte  = irc_lt_pkg::feed(ph_mid, cnt_mid, data_byte, TOP);

        phase_next = do_byte ? f_byte.phase : ph_mid;
        count_next = do_byte ? f_byte.count : cnt_mid;
        end_count  = (phase_next == irc_lt_pkg::PH_PARAM_REST) ?
                     irc_lt_pkg::bump(count_next, TOP) : count_next;
        cr_next    = is_cr && !end_of_line;

        push_valid[0] = do_cr && f_cr.emit;
        push_valid[1] = do_byte && f_byte.emit;
        push_valid[2] = end_of_line;

        push_rec[0] = f_cr.rec;
        push_rec[1] = f_byte.rec;
        push_rec[2] = irc_lt_pkg::mk_rec(8'd0, irc_lt_pkg::KIND_END, end_count, 1'b0);
        push_rec[0].last_of_run = !end_of_line && !push_valid[1];
        push_rec[1].last_of_run = !end_of_line;
        push_rec[2].last_of_run = 1'b1;

        if (end_of_line)
        begin
            phase_next = irc_lt_pkg::PH_LINE_START;
            count_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= irc_lt_pkg::PH_LINE_START;
            cr_reg    <= 1'b0;
            count_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            count_reg <= count_next;
        end
    end

    assign status.at_line_start = (phase_reg == irc_lt_pkg::PH_LINE_START) && (count_reg == 4'd0);
    assign status.cr_pending    = cr_reg;

endmodule

FILE: src/irc_lt_outq.sv
// Result queue: takes up to three results a cycle, hands one out a cycle from its head on a pop.
module irc_lt_outq (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [irc_lt_pkg::PUSH_MAX-1:0]             push_valid,
    input  irc_lt_pkg::rec_t [irc_lt_pkg::PUSH_MAX-1:0] push_rec,
    input  logic                                        pop,
    output irc_lt_pkg::rec_t                            head,
    output logic                                        head_valid,
    output logic [2:0]                                  fill
);

    localparam int DEPTH = irc_lt_pkg::QUEUE_DEPTH;

    irc_lt_pkg::rec_t [DEPTH-1:0] entry_reg, entry_next;
    logic [2:0]                   count_reg, count_next;
    logic [2:0]                   base;
    logic [2:0]                   rank [irc_lt_pkg::PUSH_MAX];
    logic [2:0]                   npush;

    always_comb
    begin
        base    = count_reg - {2'b00, pop};
        rank[0] = base;
        rank[1] = base + {2'b00, push_valid[0]};
        rank[2] = rank[1] + {2'b00, push_valid[1]};
        npush   = {2'b00, push_valid[0]} + {2'b00, push_valid[1]} + {2'b00, push_valid[2]};
        count_next = base + npush;

        for (int i = 0; i < DEPTH; i++)
        begin
            // shift towards the head on a pop, then drop new results into their slots
            if (pop && i < DEPTH - 1)
                entry_next[i] = entry_reg[i + 1];
            else
                entry_next[i] = entry_reg[i];
            for (int k = 0; k < irc_lt_pkg::PUSH_MAX; k++)
            begin
                if (push_valid[k] && rank[k] == 3'(i))
                    entry_next[i] = push_rec[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign head       = entry_reg[0];
    assign head_valid = (count_reg != 3'd0);
    assign fill       = count_reg;

endmodule

FILE: src/irc_line_tokenizer_top.sv
// Top level of the IRC line tokenizer: stream ports, parser and result queue.
// Usage:
//   Feed one raw byte of a message line per item on the s_axis channel, with
//   s_axis_tlast high on the line's final byte. Each item yields zero to three
//   tagged results on m_axis: a held-back CR, the byte itself, and on the last
//   byte an end-of-line item carrying the parameter count.
//   m_axis_tlast marks the final result caused by one input item.
// A result is registered in the queue and offered from its head in queue order.
// Throughput: one input item per cycle while each item yields at most one
//   result and m_axis_tready is high; the output side drains one result per
//   cycle from a four-entry queue, s_axis_tready high while at most one is queued.
// Stalls: when m_axis_tready is low, results wait in the queue and the head
//   holds on the port; input is refused once the queue cannot take three more.
// Reset: rst_n clears the parse position, the held CR, the parameter count and
//   the queue; with the queue empty, s_axis_tready is high once reset is released.
module irc_line_tokenizer_top #(
    parameter int MAX_PARAMS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] param_index, [15:12] zero
    output logic [3:0]  m_axis_tuser,   // [2:0] field_kind, [3] token_start
    output logic        m_axis_tlast    // last_of_run
);

    logic                                        accept;
    logic [irc_lt_pkg::PUSH_MAX-1:0]             push_valid;
    irc_lt_pkg::rec_t [irc_lt_pkg::PUSH_MAX-1:0] push_rec;
    irc_lt_pkg::parse_status_t                   status;
    irc_lt_pkg::rec_t                            head;
    logic                                        head_valid;
    logic [2:0]                                  fill;
    logic                                        pop;

    assign s_axis_tready = (fill <= 3'd1);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = head_valid && m_axis_tready;

    irc_lt_parse #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_axis_tdata),
        .end_of_line (s_axis_tlast),
        .push_valid  (push_valid),
        .push_rec    (push_rec),
        .status      (status)
    );

    irc_lt_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (accept ? push_valid : '0),
        .push_rec   (push_rec),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .fill       (fill)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {4'd0, head.param_index, head.out_byte};
    assign m_axis_tuser  = {head.token_start, head.field_kind};
    assign m_axis_tlast  = head.last_of_run;

    // queue never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill <= 3'(irc_lt_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // a line's last byte always returns the parser to line start with no CR held
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> status.at_line_start && !status.cr_pending)
        else $error("parser state not cleared after end of line");

    // an end-of-line result closes its run and carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == irc_lt_pkg::KIND_END |->
            m_axis_tlast && m_axis_tdata[7:0] == 8'd0 && !m_axis_tuser[3])
        else $error("malformed end-of-line result");

    // an accepted item that yields results makes the output valid next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (push_valid != '0) |=> m_axis_tvalid)
        else $error("results lost after accept");

endmodule

FILE: tb/irc_line_tokenizer_top_test.sv
// Self-checking testbench for the IRC line tokenizer: directed lines, then random lines.
module irc_line_tokenizer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PARAM_LIMIT  = 15;
    localparam logic [3:0] PARAM_TOP    = (PARAM_LIMIT > 15) ? 4'd15 : 4'(PARAM_LIMIT);
    localparam int         STALL_LIMIT  = 500;
    localparam int         RANDOM_ITEMS = 175;

    typedef struct packed {
        logic [7:0]        chr;
        irc_lt_pkg::kind_t kind;
        logic [3:0]        idx;
        logic              start;
        logic              last;
    } tag_rec_t;

    // How a stimulus row gets its expectation: from the predictor, none, or one typed in.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_ONE
    } row_mode_t;

    typedef struct packed {
        logic [7:0] chr;
        logic       eol;
        row_mode_t  mode;
        tag_rec_t   want;
    } stim_row_t;

    localparam tag_rec_t NO_TAG = '{8'h00, irc_lt_pkg::KIND_END, 4'd0, 1'b0, 1'b0};
    localparam tag_rec_t END_0  = '{8'h00, irc_lt_pkg::KIND_END, 4'd0, 1'b0, 1'b1};
    localparam tag_rec_t END_1  = '{8'h00, irc_lt_pkg::KIND_END, 4'd1, 1'b0, 1'b1};

    localparam int SCRIPT_LEN = 27;
    localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
        '{irc_lt_pkg::CH_LF,    1'b1, ROW_ONE,     END_0},   // empty line
        '{irc_lt_pkg::CH_CR,    1'b1, ROW_ONE,     END_0},   // lone final CR
        '{irc_lt_pkg::CH_COLON, 1'b0, ROW_SILENT,  NO_TAG},
        '{"p",      1'b0, ROW_ONE,     '{"p", irc_lt_pkg::KIND_PREFIX, 4'd0, 1'b1, 1'b1}},
        '{irc_lt_pkg::CH_SPACE, 1'b0, ROW_SILENT,  NO_TAG},
        '{"j",      1'b0, ROW_ONE,     '{"J", irc_lt_pkg::KIND_CMD, 4'd0, 1'b1, 1'b1}},
        '{irc_lt_pkg::CH_SPACE, 1'b0, ROW_SILENT,  NO_TAG},
        '{irc_lt_pkg::CH_COLON, 1'b0, ROW_SILENT,  NO_TAG},
        '{"x",      1'b0, ROW_ONE,     '{"x", irc_lt_pkg::KIND_TRAIL, 4'd0, 1'b1, 1'b1}},
        '{irc_lt_pkg::CH_CR,    1'b0, ROW_SILENT,  NO_TAG},
        '{irc_lt_pkg::CH_LF,    1'b1, ROW_ONE,     END_0},   // final CR LF, both stripped
        '{irc_lt_pkg::CH_SPACE, 1'b0, ROW_SILENT,  NO_TAG},  // empty command
        '{"a",      1'b0, ROW_ONE,     '{"a", irc_lt_pkg::KIND_PARAM, 4'd0, 1'b1, 1'b1}},
        '{irc_lt_pkg::CH_CR,    1'b0, ROW_SILENT,  NO_TAG},
        '{"b",      1'b0, ROW_PREDICT, NO_TAG},  // held CR released as a byte
        '{irc_lt_pkg::CH_CR,    1'b1, ROW_ONE,     END_1},
        '{8'hFF,    1'b1, ROW_PREDICT, NO_TAG},
        '{"z",      1'b0, ROW_ONE,     '{"Z", irc_lt_pkg::KIND_CMD, 4'd0, 1'b1, 1'b1}},
        '{irc_lt_pkg::CH_COLON, 1'b0, ROW_ONE,
          '{irc_lt_pkg::CH_COLON, irc_lt_pkg::KIND_CMD, 4'd0, 1'b0, 1'b1}},
        '{irc_lt_pkg::CH_SPACE, 1'b0, ROW_SILENT,  NO_TAG},
        '{8'h00,    1'b0, ROW_ONE,     '{8'h00, irc_lt_pkg::KIND_PARAM, 4'd0, 1'b1, 1'b1}},
        '{irc_lt_pkg::CH_COLON, 1'b0, ROW_ONE,
          '{irc_lt_pkg::CH_COLON, irc_lt_pkg::KIND_PARAM, 4'd0, 1'b0, 1'b1}},
        '{irc_lt_pkg::CH_LF,    1'b1, ROW_ONE,     END_1},
        '{irc_lt_pkg::CH_COLON, 1'b0, ROW_SILENT,  NO_TAG},  // empty prefix
        '{irc_lt_pkg::CH_SPACE, 1'b0, ROW_SILENT,  NO_TAG},
        '{irc_lt_pkg::CH_CR,    1'b0, ROW_SILENT,  NO_TAG},
        '{irc_lt_pkg::CH_CR,    1'b1, ROW_PREDICT, NO_TAG}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Sideband that travels with the item on the input port.
    row_mode_t   item_mode = ROW_PREDICT;
    tag_rec_t    item_want = NO_TAG;

    bit          no_idle = 1'b0;
    int          errors = 0;
    int          stall_cycles = 0;

    // Predictor state.
    irc_lt_pkg::phase_t parse_pos = irc_lt_pkg::PH_LINE_START;
    bit          cr_held = 1'b0;
    logic [3:0]  param_total = 4'd0;

    tag_rec_t    step_tags[$];
    tag_rec_t    expected_tags[$];
    logic [7:0]  line_q[$];

    irc_line_tokenizer_top #(
        .MAX_PARAMS(PARAM_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] cmd_case(input logic [7:0] c);
        return (c >= irc_lt_pkg::CH_LC_A && c <= irc_lt_pkg::CH_LC_Z) ? c - 8'd32 : c;
    endfunction

    function automatic logic [3:0] next_count(input logic [3:0] n);
        return (n < PARAM_TOP) ? n + 4'd1 : n;
    endfunction

    task automatic add_tag(input logic [7:0] c, input irc_lt_pkg::kind_t k,
                           input logic [3:0] idx, input logic st);
        tag_rec_t t;
        t = '{c, k, idx, st, 1'b0};
        step_tags.insert(step_tags.size(), t);
    endtask

    // Advance the parse position by one byte.
    task automatic tag_char(input logic [7:0] c);
        case (parse_pos)
            irc_lt_pkg::PH_LINE_START:
            begin
                if (c == irc_lt_pkg::CH_COLON)
                    parse_pos = irc_lt_pkg::PH_PREFIX_FIRST;
                else if (c == irc_lt_pkg::CH_SPACE)
                    parse_pos = irc_lt_pkg::PH_PARAM_GAP;
                else
                begin
                    add_tag(cmd_case(c), irc_lt_pkg::KIND_CMD, 4'd0, 1'b1);
                    parse_pos = irc_lt_pkg::PH_CMD_REST;
                end
            end
            irc_lt_pkg::PH_PREFIX_FIRST, irc_lt_pkg::PH_PREFIX_REST:
            begin
                if (c == irc_lt_pkg::CH_SPACE)
                    parse_pos = irc_lt_pkg::PH_CMD_START;
                else
                begin
                    add_tag(c, irc_lt_pkg::KIND_PREFIX, 4'd0,
                            parse_pos == irc_lt_pkg::PH_PREFIX_FIRST);
                    parse_pos = irc_lt_pkg::PH_PREFIX_REST;
                end
            end
            irc_lt_pkg::PH_CMD_START:
            begin
                if (c != irc_lt_pkg::CH_SPACE)
                begin
                    add_tag(cmd_case(c), irc_lt_pkg::KIND_CMD, 4'd0, 1'b1);
                    parse_pos = irc_lt_pkg::PH_CMD_REST;
                end
            end
            irc_lt_pkg::PH_CMD_REST:
            begin
                if (c == irc_lt_pkg::CH_SPACE)
                    parse_pos = irc_lt_pkg::PH_PARAM_GAP;
                else
                    add_tag(cmd_case(c), irc_lt_pkg::KIND_CMD, 4'd0, 1'b0);
            end
            irc_lt_pkg::PH_PARAM_GAP:
            begin
                if (c == irc_lt_pkg::CH_COLON)
                    parse_pos = irc_lt_pkg::PH_TRAIL_FIRST;
                else if (c != irc_lt_pkg::CH_SPACE)
                begin
                    add_tag(c, irc_lt_pkg::KIND_PARAM, param_total, 1'b1);
                    parse_pos = irc_lt_pkg::PH_PARAM_REST;
                end
            end
            irc_lt_pkg::PH_PARAM_REST:
            begin
                if (c == irc_lt_pkg::CH_SPACE)
                begin
                    param_total = next_count(param_total);
                    parse_pos = irc_lt_pkg::PH_PARAM_GAP;
                end
                else
                    add_tag(c, irc_lt_pkg::KIND_PARAM, param_total, 1'b0);
            end
            irc_lt_pkg::PH_TRAIL_FIRST:
            begin
                add_tag(c, irc_lt_pkg::KIND_TRAIL, 4'd0, 1'b1);
                parse_pos = irc_lt_pkg::PH_TRAIL_REST;
            end
            default:
            begin
                add_tag(c, irc_lt_pkg::KIND_TRAIL, 4'd0, 1'b0);
                parse_pos = irc_lt_pkg::PH_TRAIL_REST;
            end
        endcase
    endtask

    // Work out every tag one input item causes, into step_tags.
    task automatic tokenize(input logic [7:0] c, input logic eol);
        tag_rec_t t;
        step_tags.delete();
        if (eol)
        begin
            // A final CR LF is dropped whole; otherwise release the held CR first.
            if (!(cr_held && c == irc_lt_pkg::CH_LF))
            begin
                if (cr_held)
                    tag_char(irc_lt_pkg::CH_CR);
                if (c != irc_lt_pkg::CH_LF && c != irc_lt_pkg::CH_CR)
                    tag_char(c);
            end
            if (parse_pos == irc_lt_pkg::PH_PARAM_REST)
                param_total = next_count(param_total);
            add_tag(8'h00, irc_lt_pkg::KIND_END, param_total, 1'b0);
            parse_pos   = irc_lt_pkg::PH_LINE_START;
            cr_held     = 1'b0;
            param_total = 4'd0;
        end
        else
        begin
            if (cr_held)
            begin
                tag_char(irc_lt_pkg::CH_CR);
                cr_held = 1'b0;
            end
            if (c == irc_lt_pkg::CH_CR)
                cr_held = 1'b1;
            else
                tag_char(c);
        end
        if (step_tags.size() != 0)
        begin
            t = step_tags[step_tags.size() - 1];
            t.last = 1'b1;
            step_tags[step_tags.size() - 1] = t;
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 10);

    // Check results, predict accepted items, and watch for a hang.
    always @(posedge clk)
    begin
        tag_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tags.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got tdata %h tuser %h tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = expected_tags.pop_front();
                if (m_axis_tdata[7:0] !== want.chr)
                begin
                    errors++;
                    $display("%0t: out_byte expected %h got %h",
                             $time, want.chr, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[11:8] !== want.idx)
                begin
                    errors++;
                    $display("%0t: param_index expected %0d got %0d",
                             $time, want.idx, m_axis_tdata[11:8]);
                end
                if (m_axis_tdata[15:12] !== 4'd0)
                begin
                    errors++;
                    $display("%0t: tdata padding expected 0 got %h",
                             $time, m_axis_tdata[15:12]);
                end
                if (m_axis_tuser[2:0] !== want.kind)
                begin
                    errors++;
                    $display("%0t: field_kind expected %0d got %0d",
                             $time, want.kind, m_axis_tuser[2:0]);
                end
                if (m_axis_tuser[3] !== want.start)
                begin
                    errors++;
                    $display("%0t: token_start expected %b got %b",
                             $time, want.start, m_axis_tuser[3]);
                end
                if (m_axis_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            tokenize(s_axis_tdata, s_axis_tlast);
            case (item_mode)
                ROW_PREDICT:
                    foreach (step_tags[i])
                        expected_tags.insert(expected_tags.size(), step_tags[i]);
                ROW_ONE:
                    expected_tags.insert(expected_tags.size(), item_want);
                default:
                    ;
            endcase
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one item and hold it until the block takes it.
    task automatic send_item(input logic [7:0] c, input logic eol, input row_mode_t mode,
                             input tag_rec_t want);
        while (!no_idle && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eol;
        item_mode     <= mode;
        item_want     <= want;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    function automatic logic [7:0] word_char(input bit cmd, input bit spaces_ok);
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0: c = irc_lt_pkg::CH_CR;
            1: c = irc_lt_pkg::CH_COLON;
            2: c = spaces_ok ? irc_lt_pkg::CH_SPACE : 8'h7E;
            3: c = 8'($urandom_range(0, 255));
            default:
            begin
                if (cmd)
                begin
                    c = 8'($urandom_range(irc_lt_pkg::CH_LC_A, irc_lt_pkg::CH_LC_Z));
                    if ($urandom_range(0, 1))
                        c = c ^ irc_lt_pkg::CASE_BIT;
                end
                else
                    c = 8'($urandom_range(8'h21, 8'h7E));
            end
        endcase
        return c;
    endfunction

    // Append one byte to the line being built.
    task automatic append_byte(input logic [7:0] c);
        line_q.insert(line_q.size(), c);
    endtask

    task automatic add_word(input int len, input bit cmd, input bit spaces_ok);
        repeat (len)
            append_byte(word_char(cmd, spaces_ok));
    endtask

    // Build one random line: mostly well formed, sometimes plain noise.
    task automatic build_line();
        int n_par;
        line_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(0, 4))
                    0: append_byte(irc_lt_pkg::CH_COLON);
                    1: append_byte(irc_lt_pkg::CH_SPACE);
                    2: append_byte(irc_lt_pkg::CH_CR);
                    3: append_byte(irc_lt_pkg::CH_LF);
                    default: append_byte(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        if ($urandom_range(0, 1))
        begin
            append_byte(irc_lt_pkg::CH_COLON);
            add_word($urandom_range(0, 4), 1'b0, 1'b0);
            append_byte(irc_lt_pkg::CH_SPACE);
        end
        add_word($urandom_range(1, 5), 1'b1, 1'b0);
        // Now and then run past the top parameter index.
        n_par = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 4);
        repeat (n_par)
        begin
            repeat ($urandom_range(1, 2))
                append_byte(irc_lt_pkg::CH_SPACE);
            add_word($urandom_range(1, 3), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 1))
        begin
            append_byte(irc_lt_pkg::CH_SPACE);
            append_byte(irc_lt_pkg::CH_COLON);
            add_word($urandom_range(0, 6), 1'b0, 1'b1);
        end
        case ($urandom_range(0, 3))
            0:
            begin
                append_byte(irc_lt_pkg::CH_CR);
                append_byte(irc_lt_pkg::CH_LF);
            end
            1: append_byte(irc_lt_pkg::CH_LF);
            2: append_byte(irc_lt_pkg::CH_CR);
            default: ;
        endcase
    endtask

    initial
    begin
        int sent;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        foreach (SCRIPT[i])
            send_item(SCRIPT[i].chr, SCRIPT[i].eol, SCRIPT[i].mode, SCRIPT[i].want);
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            build_line();
            no_idle = (sent >= 100 && sent < 160);
            foreach (line_q[i])
            begin
                send_item(line_q[i], i == line_q.size() - 1, ROW_PREDICT, NO_TAG);
                sent++;
            end
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
src/irc_lt_pkg.sv
src/irc_lt_parse.sv
src/irc_lt_outq.sv
src/irc_line_tokenizer_top.sv
tb/irc_line_tokenizer_top_test.sv
